// ----- rtl/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and hex helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Character codes recognised by the decoder.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Most result bytes that one input item can cause.
  localparam int MAX_RESULTS = 3;

  // One input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Work handed from front to back: up to three bytes for one input item.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  count;
    logic                        last;
  } upd_cmd_t;

  // Status of the queue, seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } upd_qstat_t;

  // Escape tracking state.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_t;

  // True for 0-9, A-F and a-f.
  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Value of a hex digit; only meaningful where is_hex holds.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= 8'h61) ? (c - 8'h20) : c;
    if (u >= 8'h41) begin
      hex_value = 4'(u - 8'h37);
    end else begin
      hex_value = 4'(u - 8'h30);
    end
  endfunction

endpackage

// ----- rtl/url_percent_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// Streaming URL percent decoder that also turns '+' into a space.
// ----------------------------------------------------------------------------
// Usage: encoded bytes arrive on the input channel (in_valid, in_stall,
// in_item), one per item, with in_last on the final byte of a string.
// Decoded bytes leave on the output channel (out_valid, out_stall, out_item),
// with out_last on the final decoded byte. An item is taken at a clock edge
// where valid is high and stall is low.
// A byte that produces output is written into the queue at the edge that
// takes it; its first result is then loaded into the output register.
// Throughput: one input item per cycle while its results keep pace; one
// output item per cycle while the receiver does not stall, so an item that
// yields three bytes (a malformed escape) takes three output items.
// The queue between front and back, of QueueDepth entries, absorbs these bursts.
// A '%' or a first hex digit produces nothing until the escape resolves.
// Reset clears the escape state, empties the queue and drops out_valid.
// While the receiver stalls, the output item holds; once the queue fills,
// in_stall rises and input is held off.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit import upd_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  upd_cmd_t   front_cmd;
  upd_cmd_t   head_cmd;
  upd_qstat_t qstat;
  logic       push;
  logic       pop;

  // Front: classify bytes and track escapes.
  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .qstat    (qstat),
    .push     (push),
    .cmd      (front_cmd)
  );

  // Queue between the two halves.
  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .qstat    (qstat)
  );

  // Back: emit the bytes one at a time.
  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_cmd),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/upd_front.sv -----
// ----------------------------------------------------------------------------
// upd_front
// Accepts encoded bytes, tracks pending escapes and forms the list of bytes
// that each item produces.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  input  upd_qstat_t qstat,
  output logic       push,
  output upd_cmd_t   cmd
);

  upd_phase_t phase, phase_mid, phase_next;
  logic [7:0] held, held_next;
  logic       accept;
  logic       b_hex;
  logic       b_pct;
  logic       plain_emits;
  logic [7:0] plain_out;
  logic [7:0] decoded;

  // Classification of the incoming byte.
  assign b_hex       = is_hex(in_item.in_byte);
  assign b_pct       = (in_item.in_byte == CH_PERCENT);
  assign plain_emits = !b_pct;
  assign plain_out   = (in_item.in_byte == CH_PLUS) ? CH_SPACE : in_item.in_byte;
  assign decoded     = {hex_value(held), hex_value(in_item.in_byte)};

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;
  assign push     = accept && (cmd.count != 2'd0);

  // Next escape state; the mid value is the state before any end-of-string flush.
  always_comb begin
    held_next = held;
    unique case (phase)
      PH_PCT: begin
        if (b_hex) begin
          phase_mid = PH_DIGIT;
          held_next = in_item.in_byte;
        end else begin
          phase_mid = b_pct ? PH_PCT : PH_IDLE;
        end
      end
      PH_DIGIT: begin
        if (b_hex) begin
          phase_mid = PH_IDLE;
        end else begin
          phase_mid = b_pct ? PH_PCT : PH_IDLE;
        end
      end
      default: begin
        phase_mid = b_pct ? PH_PCT : PH_IDLE;
      end
    endcase
    phase_next = in_item.in_last ? PH_IDLE : phase_mid;
  end

  // Bytes produced by this item, in order.
  always_comb begin
    cmd.bytes = '0;
    cmd.count = 2'd0;
    cmd.last  = in_item.in_last;
    unique case (phase)
      PH_PCT: begin
        if (!b_hex) begin
          cmd.bytes[0] = CH_PERCENT;
          if (plain_emits) begin
            cmd.bytes[1] = plain_out;
            cmd.count    = 2'd2;
          end else begin
            cmd.count = 2'd1;
          end
        end
      end
      PH_DIGIT: begin
        if (b_hex) begin
          cmd.bytes[0] = decoded;
          cmd.count    = 2'd1;
        end else begin
          cmd.bytes[0] = CH_PERCENT;
          cmd.bytes[1] = held;
          if (plain_emits) begin
            cmd.bytes[2] = plain_out;
            cmd.count    = 2'd3;
          end else begin
            cmd.count = 2'd2;
          end
        end
      end
      default: begin
        if (plain_emits) begin
          cmd.bytes[0] = plain_out;
          cmd.count    = 2'd1;
        end
      end
    endcase
    // At the end of the string a pending escape is flushed literally.
    if (in_item.in_last) begin
      if (phase_mid == PH_PCT) begin
        cmd.bytes[cmd.count] = CH_PERCENT;
        cmd.count            = cmd.count + 2'd1;
      end else if (phase_mid == PH_DIGIT) begin
        cmd.bytes[0] = CH_PERCENT;
        cmd.bytes[1] = held_next;
        cmd.count    = 2'd2;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept) begin
      held <= held_next;
    end
  end

endmodule

// ----- rtl/upd_queue.sv -----
// ----------------------------------------------------------------------------
// upd_queue
// Short first-in first-out queue of decode work between front and back.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  upd_cmd_t   push_cmd,
  input  logic       pop,
  output upd_cmd_t   head,
  output upd_qstat_t qstat
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  upd_cmd_t        entries [Depth];
  logic [AW-1:0]   wptr, rptr;
  logic [CW-1:0]   fill;

  assign qstat.full  = (fill == CW'(Depth));
  assign qstat.empty = (fill == '0);
  assign head        = entries[rptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/upd_back.sv -----
// ----------------------------------------------------------------------------
// upd_back
// Walks the bytes of the head work entry and presents them one item per
// cycle, while the receiver does not stall, through an output register.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  upd_cmd_t   head,
  input  upd_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  // The register loads whenever work is queued and it is empty or being taken.
  assign load   = !qstat.empty && (!out_valid || !out_stall);
  assign at_end = (idx == head.count - 2'd1);
  assign pop    = load && at_end;

  // Byte index within the head entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.out_byte <= head.bytes[idx];
      out_item.out_last <= head.last && at_end;
    end
  end

endmodule

// ----- rtl/upd_checker.sv -----
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks of the decoder's channels, bound to the top level.
// ----------------------------------------------------------------------------
module upd_checker import upd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A stalled input item stays offered and does not change.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("input item changed while stalled");

  // A stalled output item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item withdrawn while stalled");

  // A stalled output item does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_item))
    else $error("output item changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // The input is open in the cycle after reset, since the queue is empty.
  a_reset_open: assert property (@(posedge clk)
    $past(rst) |-> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ----- dv/url_percent_decoder_checker.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder_checker
// Watches both channels of the URL percent decoder, works out the decoded
// bytes for every accepted encoded byte and compares them, in order, with the
// bytes that leave the block. It hands the number of faults and the number of
// decoded bytes still awaited to the testbench top.
// ----------------------------------------------------------------------------
module url_percent_decoder_checker import upd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fault_count,
  output int        pending_results
);

  // Most faults that are reported in full; later ones are only counted.
  localparam int REPORT_CAP = 20;

  // Escape tracking of the predictor and the decoded bytes still awaited.
  upd_phase_t esc_phase;
  logic [7:0] first_digit;
  out_item_t  decoded_q[$];
  out_item_t  want;

  // A digit, or a letter a to f in either case.
  function automatic bit is_hex_char(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    return (c >= "0" && c <= "9") || (folded >= "a" && folded <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= "0" && c <= "9") begin
      return 4'(c - "0");
    end
    return 4'(folded - "a" + 8'd10);
  endfunction

  // Works out the decoded bytes caused by one encoded byte and queues them.
  function automatic void decode_step(input in_item_t it);
    logic [7:0] produced[$];
    logic [7:0] b;
    bit         plain;
    out_item_t  r;
    b     = it.in_byte;
    plain = 1'b0;
    case (esc_phase)
      PH_PCT: begin
        if (is_hex_char(b)) begin
          first_digit = b;
          esc_phase   = PH_DIGIT;
        end else begin
          // The '%' was not an escape after all: it goes out as it is.
          produced.push_back(CH_PERCENT);
          esc_phase = PH_IDLE;
          plain     = 1'b1;
        end
      end
      PH_DIGIT: begin
        esc_phase = PH_IDLE;
        if (is_hex_char(b)) begin
          produced.push_back({nibble_of(first_digit), nibble_of(b)});
        end else begin
          produced.push_back(CH_PERCENT);
          produced.push_back(first_digit);
          plain = 1'b1;
        end
      end
      default: begin
        esc_phase = PH_IDLE;
        plain     = 1'b1;
      end
    endcase

    // The byte is seen afresh, so a '%' here opens a new escape.
    if (plain) begin
      if (b == CH_PERCENT) begin
        esc_phase = PH_PCT;
      end else if (b == CH_PLUS) begin
        produced.push_back(CH_SPACE);
      end else begin
        produced.push_back(b);
      end
    end

    // At the end of a string a pending escape is flushed literally.
    if (it.in_last) begin
      if (esc_phase == PH_PCT) begin
        produced.push_back(CH_PERCENT);
      end else if (esc_phase == PH_DIGIT) begin
        produced.push_back(CH_PERCENT);
        produced.push_back(first_digit);
      end
      esc_phase = PH_IDLE;
    end

    foreach (produced[i]) begin
      r.out_byte = produced[i];
      r.out_last = it.in_last && (i == produced.size() - 1);
      decoded_q.push_back(r);
    end
  endfunction

  // Outputs are compared before the new item is predicted: a byte taken at
  // this edge cannot have a result at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      fault_count = 0;
      esc_phase   = PH_IDLE;
      first_digit = 8'h00;
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_CAP) begin
            $display("%0t: unexpected item: expected none, got byte %h last %b",
                     $time, out_item.out_byte, out_item.out_last);
          end
        end else begin
          want = decoded_q.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            fault_count++;
            if (fault_count <= REPORT_CAP) begin
              $display("%0t: out_byte mismatch: expected %h, got %h",
                       $time, want.out_byte, out_item.out_byte);
            end
          end
          if (out_item.out_last !== want.out_last) begin
            fault_count++;
            if (fault_count <= REPORT_CAP) begin
              $display("%0t: out_last mismatch: expected %b, got %b",
                       $time, want.out_last, out_item.out_last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_step(in_item);
      end
    end
    pending_results <= decoded_q.size();
  end

endmodule

// ----- dv/url_percent_decoder_unit_tb.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder_unit_tb
// Drives encoded strings into the URL percent decoder: a short directed run
// over escapes, malformed escapes, '+' and flushing at the end of a string,
// then random strings, mostly well formed, with some noise. Both sides idle
// at random and the receiver once holds off long enough to fill the block.
// The checker beside the block judges every decoded byte.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit_tb;
  import upd_pkg::*;

  localparam int TOTAL_ITEMS    = 410;
  localparam int CALM_FROM      = TOTAL_ITEMS - 60;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 200000;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        fault_count;
  int        pending_results;

  // Stimulus bookkeeping shared by the sender and the receiver.
  int         sent_items    = 0;
  bit         quiet_tail    = 1'b0;
  bit         long_hold_req = 1'b0;
  int         tx_calm_left  = 0;
  int         rx_calm_left  = 0;
  int         rx_hold_left  = 0;
  int         cycle_count   = 0;
  logic [7:0] enc_text[$];

  always #1 clk = ~clk;

  url_percent_decoder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  url_percent_decoder_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .fault_count    (fault_count),
    .pending_results(pending_results)
  );

  // Gives up on a run that has hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, calm stretches and one long hold-off.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold_left  = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (quiet_tail) begin
        out_stall <= 1'b0;
      end else if (rx_calm_left > 0) begin
        rx_calm_left--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        rx_calm_left = $urandom_range(10, 50);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        rx_hold_left = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one item, perhaps after an idle burst, and returns at the edge
  // where it is taken.
  task automatic send_item(input logic [7:0] b, input logic last);
    if (quiet_tail) begin
      // No idling near the end of the run.
    end else if (tx_calm_left > 0) begin
      tx_calm_left--;
    end else if ($urandom_range(0, 24) == 0) begin
      tx_calm_left = $urandom_range(10, 40);
    end else if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_item.in_byte <= b;
    in_item.in_last <= last;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (sent_items >= CALM_FROM) begin
      quiet_tail = 1'b1;
    end
  endtask

  // Sends the text built up so far as one string and clears it.
  task automatic send_text();
    foreach (enc_text[i]) begin
      send_item(enc_text[i], i == enc_text.size() - 1);
    end
    enc_text.delete();
  endtask

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      return 8'("0" + v);
    end
    return $urandom_range(0, 1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  // A byte that cannot be a hex digit; '%' and '+' are favoured.
  function automatic logic [7:0] random_non_hex_char();
    case ($urandom_range(0, 5))
      0: return CH_PERCENT;
      1: return CH_PLUS;
      2: return 8'($urandom_range(8'h00, 8'h2F));
      3: return 8'($urandom_range(8'h3A, 8'h40));
      4: return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  // Builds a random string of escapes, pluses, plain bytes and broken
  // escapes, sometimes ending inside an escape.
  task automatic build_random_text();
    int tokens;
    tokens = $urandom_range(1, 10);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          enc_text.push_back(CH_PERCENT);
          enc_text.push_back(random_hex_char());
          enc_text.push_back(random_hex_char());
        end
        4: enc_text.push_back(CH_PLUS);
        5, 6: enc_text.push_back(8'($urandom_range(0, 255)));
        7: begin
          enc_text.push_back(CH_PERCENT);
          enc_text.push_back(random_non_hex_char());
        end
        8: begin
          enc_text.push_back(CH_PERCENT);
          enc_text.push_back(random_hex_char());
          enc_text.push_back(random_non_hex_char());
        end
        default: enc_text.push_back(CH_PERCENT);
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      enc_text.push_back(CH_PERCENT);
      if ($urandom_range(0, 1)) begin
        enc_text.push_back(random_hex_char());
      end
    end
  endtask

  // Reset, directed strings, random strings, drain and verdict.
  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Extreme bytes, a zero byte and a plus, all in one string.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_PLUS, 1'b0);
    // Well-formed escapes in upper and lower case, one decoding to zero.
    send_item(CH_PERCENT, 1'b0);
    send_item("4", 1'b0);
    send_item("1", 1'b0);
    send_item(CH_PERCENT, 1'b0);
    send_item("f", 1'b0);
    send_item("F", 1'b0);
    send_item(CH_PERCENT, 1'b0);
    send_item("0", 1'b0);
    send_item("0", 1'b0);
    // Bad second character.
    send_item(CH_PERCENT, 1'b0);
    send_item("G", 1'b0);
    // Bad third character that is itself a plus.
    send_item(CH_PERCENT, 1'b0);
    send_item("a", 1'b0);
    send_item(CH_PLUS, 1'b0);
    // A '%' after a '%' opens a fresh escape.
    send_item(CH_PERCENT, 1'b0);
    send_item(CH_PERCENT, 1'b0);
    send_item("4", 1'b0);
    send_item("1", 1'b0);
    // End of string right after the '%' and after the first digit.
    send_item(CH_PERCENT, 1'b1);
    send_item(CH_PERCENT, 1'b0);
    send_item("9", 1'b1);
    send_item("z", 1'b1);

    // The receiver holds off while the sender keeps offering items.
    long_hold_req = 1'b1;
    tx_calm_left  = 40;

    while (sent_items < TOTAL_ITEMS) begin
      if ($urandom_range(0, 6) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        build_random_text();
        send_text();
      end
    end
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
